FILE: design/cwk_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the Chebyshev window kernel evaluator.
// Used by the channel interfaces, the top level and the bench; depends on nothing.
package cwk_pkg;

  // Default table and point limits.
  localparam int MAX_TERMS  = 32;
  localparam int MAX_POINTS = 16;

  // Payload widths.
  localparam int CoefIdxW  = 5;
  localparam int DataW     = 32;
  localparam int PointIdxW = 4;

  // Configuration port.
  localparam int PAddrW = 5;
  localparam logic [2:0] REG_DOMAIN_LOW  = 3'd0;
  localparam logic [2:0] REG_DOMAIN_HIGH = 3'd1;
  localparam logic [2:0] REG_NUM_TERMS   = 3'd2;
  localparam logic [2:0] REG_POINTS_OUT  = 3'd3;
  localparam logic [2:0] REG_HALF_OFFSET = 3'd4;

  localparam logic signed [31:0] DOMAIN_LOW_RST  = -32'sd16777216;
  localparam logic signed [31:0] DOMAIN_HIGH_RST = 32'sd16777216;
  localparam logic [5:0]         NUM_TERMS_RST   = 6'd16;
  localparam logic [4:0]         POINTS_OUT_RST  = 5'd8;
  localparam logic [4:0]         HALF_OFFSET_RST = 5'd4;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Internal datapath widths.
  localparam int XW   = 36;  // position, Q8.24 with headroom for offsets
  localparam int NW   = 38;  // 2x - a - b
  localparam int DenW = 33;  // b - a
  localparam int QW   = 33;  // quotient magnitude bits
  localparam int RW   = 65;  // |num| * 2^28
  localparam int DSW  = 66;  // |den| * 2^33
  localparam int DivStepsM1 = 33;

endpackage

FILE: design/cwk_req_if.sv
`timescale 1ns / 1ps
// Input channel of the kernel evaluator: load and evaluate requests.
// Depends on cwk_pkg for field widths.
interface cwk_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [cwk_pkg::CoefIdxW-1:0]         coef_index;
  logic signed [cwk_pkg::DataW-1:0]     coef_value;
  logic signed [cwk_pkg::DataW-1:0]     position;

  modport source(output valid, req_type, coef_index, coef_value, position, input ready);
  modport sink(input valid, req_type, coef_index, coef_value, position, output ready);
endinterface

FILE: design/cwk_res_if.sv
`timescale 1ns / 1ps
// Output channel of the kernel evaluator: one word per kernel point.
// Depends on cwk_pkg for field widths.
interface cwk_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cwk_pkg::DataW-1:0]     kernel_value;
  logic [cwk_pkg::PointIdxW-1:0]        point_index;
  logic                                 last_point;

  modport source(output valid, kernel_value, point_index, last_point, input ready);
  modport sink(input valid, kernel_value, point_index, last_point, output ready);
endinterface

FILE: design/cwk_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cwk_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/chebyshev_window_kernel_evaluator.sv
`timescale 1ns / 1ps
// Chebyshev window kernel evaluator. A load word writes one Q4.28 coefficient;
// an evaluate word starts points_out results at positions x+half_offset,
// x+half_offset-1, ... For each point a shift-subtract divider maps x to
// y=(2x-a-b)/(b-a) (skipped when b equals a), then the Clenshaw step runs
// per coefficient through one 32x32 multiplier and the coefficient RAM read
// port. The request channel is not ready while an evaluate word is in work.
// Depends on cwk_pkg, cwk_req_if, cwk_res_if and cwk_ram.
module chebyshev_window_kernel_evaluator #(
  parameter int MaxTerms  = cwk_pkg::MAX_TERMS,
  parameter int MaxPoints = cwk_pkg::MAX_POINTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cwk_req_if.sink                    req_i,
  cwk_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cwk_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW  = $clog2(MaxTerms);
  localparam int TCW = $clog2(MaxTerms + 1);
  localparam int PCW = $clog2(MaxPoints + 1);
  localparam int XW  = cwk_pkg::XW;
  localparam int NW  = cwk_pkg::NW;
  localparam int QW  = cwk_pkg::QW;
  localparam int RW  = cwk_pkg::RW;
  localparam int DSW = cwk_pkg::DSW;
  localparam int DenW = cwk_pkg::DenW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_YFIX,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_e;

  // ---------------- configuration registers ----------------
  logic signed [31:0] dom_low_q, dom_high_q;
  logic [5:0]         num_terms_q;
  logic [4:0]         points_out_q;
  logic [4:0]         half_offset_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_low_q     <= cwk_pkg::DOMAIN_LOW_RST;
      dom_high_q    <= cwk_pkg::DOMAIN_HIGH_RST;
      num_terms_q   <= cwk_pkg::NUM_TERMS_RST;
      points_out_q  <= cwk_pkg::POINTS_OUT_RST;
      half_offset_q <= cwk_pkg::HALF_OFFSET_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        cwk_pkg::REG_DOMAIN_LOW:  dom_low_q     <= pwdata;
        cwk_pkg::REG_DOMAIN_HIGH: dom_high_q    <= pwdata;
        cwk_pkg::REG_NUM_TERMS:   num_terms_q   <= pwdata[5:0];
        cwk_pkg::REG_POINTS_OUT:  points_out_q  <= pwdata[4:0];
        cwk_pkg::REG_HALF_OFFSET: half_offset_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      cwk_pkg::REG_DOMAIN_LOW:  prdata = dom_low_q;
      cwk_pkg::REG_DOMAIN_HIGH: prdata = dom_high_q;
      cwk_pkg::REG_NUM_TERMS:   prdata = {26'd0, num_terms_q};
      cwk_pkg::REG_POINTS_OUT:  prdata = {27'd0, points_out_q};
      cwk_pkg::REG_HALF_OFFSET: prdata = {27'd0, half_offset_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------- clamped counts ----------------
  logic [TCW-1:0] n_lim;
  logic [PCW-1:0] p_lim;

  always_comb begin
    if (32'(num_terms_q) > MaxTerms) begin
      n_lim = TCW'(MaxTerms);
    end else begin
      n_lim = TCW'(num_terms_q);
    end
    // Zero terms behaves as one term.
    if (n_lim == '0) begin
      n_lim = TCW'(1);
    end
    if (32'(points_out_q) > MaxPoints) begin
      p_lim = PCW'(MaxPoints);
    end else begin
      p_lim = PCW'(points_out_q);
    end
  end

  // ---------------- state ----------------
  state_e                 state_q, state_d;
  logic signed [XW-1:0]   x_q;
  logic [PCW-1:0]         j_q;
  logic [TCW-1:0]         i_q;
  logic [5:0]             div_cnt_q;
  logic [RW-1:0]          rem_q;
  logic [DSW-1:0]         dsh_q;
  logic [QW-1:0]          quo_q;
  logic                   ovf_q;
  logic                   qneg_q;
  logic signed [31:0]     y_q;
  logic signed [31:0]     d_q, d1_q;
  logic signed [63:0]     prod_q;
  logic signed [31:0]     kv_q;
  logic                   out_valid_q;
  logic signed [31:0]     out_kv_q;
  logic [cwk_pkg::PointIdxW-1:0] out_idx_q;
  logic                   out_last_q;

  logic req_acc, out_free, last_pt;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign last_pt     = (j_q + PCW'(1)) == p_lim;

  // ---------------- coefficient RAM ----------------
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  assign ram_we = req_acc && (req_i.req_type == cwk_pkg::REQ_LOAD) &&
                  (32'(req_i.coef_index) < MaxTerms);
  // At the last step the read falls on entry 0 for the half-weight c0 term.
  assign ram_raddr = AW'(i_q - TCW'(1));

  cwk_ram #(
    .Width(32),
    .Depth(MaxTerms)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(req_i.coef_index)),
    .wdata_i (req_i.coef_value),
    .re_i    (state_q == S_MUL),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- position mapping ----------------
  logic signed [NW-1:0]   num;
  logic signed [DenW-1:0] den;
  logic [NW-1:0]          num_mag;
  logic [DenW-1:0]        den_mag;

  always_comb begin
    num = {{(NW-XW-1){x_q[XW-1]}}, x_q, 1'b0}
        - {{(NW-32){dom_low_q[31]}}, dom_low_q}
        - {{(NW-32){dom_high_q[31]}}, dom_high_q};
    den = {dom_high_q[31], dom_high_q} - {dom_low_q[31], dom_low_q};
    num_mag = num[NW-1] ? -num : num;
    den_mag = den[DenW-1] ? -den : den;
  end

  // One shift-subtract step of the divider. The first step only checks for
  // a quotient of 2^33 or more, which saturates in any case.
  logic          div_ge;
  logic [RW-1:0] rem_sub;
  assign div_ge  = {1'b0, rem_q} >= dsh_q;
  assign rem_sub = rem_q - dsh_q[RW-1:0];

  logic signed [31:0] y_fix;
  always_comb begin
    if (!qneg_q) begin
      if (ovf_q || quo_q[32] || quo_q[31]) begin
        y_fix = 32'sh7FFF_FFFF;
      end else begin
        y_fix = quo_q[31:0];
      end
    end else begin
      if (ovf_q || quo_q[32] || (quo_q[31] && (quo_q[30:0] != '0))) begin
        y_fix = 32'sh8000_0000;
      end else begin
        y_fix = -quo_q[31:0];
      end
    end
  end

  // ---------------- Clenshaw step ----------------
  logic               fin_step;
  logic signed [63:0] prod_rnd;
  logic signed [36:0] rnd_term;
  logic [32:0]        c_inc;
  logic signed [31:0] c_term;
  logic signed [38:0] acc;
  logic signed [31:0] acc_sat;

  always_comb begin
    fin_step = (i_q == TCW'(1));
    prod_rnd = prod_q + (fin_step ? 64'sd134217728 : 64'sd67108864);
    if (fin_step) begin
      rnd_term = {prod_rnd[63], prod_rnd[63:28]};
    end else begin
      rnd_term = prod_rnd[63:27];
    end
    c_inc  = {ram_rdata[31], ram_rdata} + 33'd1;
    c_term = fin_step ? c_inc[32:1] : ram_rdata;
    acc = {{2{rnd_term[36]}}, rnd_term}
        - {{7{d1_q[31]}}, d1_q}
        + {{7{c_term[31]}}, c_term};
    if (acc[38:31] == '0 || acc[38:31] == '1) begin
      acc_sat = acc[31:0];
    end else if (acc[38]) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = 32'sh7FFF_FFFF;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc && req_i.req_type == cwk_pkg::REQ_EVAL && p_lim != '0) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: state_d = (den == '0) ? S_MUL : S_DIV;
      S_DIV:   state_d = (div_cnt_q == '0) ? S_YFIX : S_DIV;
      S_YFIX:  state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = fin_step ? S_EMIT : S_MUL;
      S_EMIT: begin
        if (out_free) begin
          state_d = last_pt ? S_IDLE : S_SETUP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      j_q         <= '0;
      i_q         <= TCW'(1);
      div_cnt_q   <= '0;
      rem_q       <= '0;
      dsh_q       <= '0;
      quo_q       <= '0;
      ovf_q       <= 1'b0;
      qneg_q      <= 1'b0;
      y_q         <= '0;
      d_q         <= '0;
      d1_q        <= '0;
      prod_q      <= '0;
      kv_q        <= '0;
      out_valid_q <= 1'b0;
      out_kv_q    <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            x_q <= {{(XW-32){req_i.position[31]}}, req_i.position}
                 + {{(XW-29){1'b0}}, half_offset_q, 24'd0};
            j_q <= '0;
          end
        end
        S_SETUP: begin
          rem_q     <= {num_mag[NW-2:0], 28'd0};
          dsh_q     <= {den_mag, 33'd0};
          quo_q     <= '0;
          ovf_q     <= 1'b0;
          qneg_q    <= num[NW-1] ^ den[DenW-1];
          div_cnt_q <= 6'(cwk_pkg::DivStepsM1);
          i_q       <= n_lim;
          d_q       <= '0;
          d1_q      <= '0;
          // An empty domain saturates y by the sign of the numerator.
          if (num == '0) begin
            y_q <= '0;
          end else if (num[NW-1]) begin
            y_q <= 32'sh8000_0000;
          end else begin
            y_q <= 32'sh7FFF_FFFF;
          end
        end
        S_DIV: begin
          if (div_cnt_q == 6'(cwk_pkg::DivStepsM1)) begin
            ovf_q <= div_ge;
          end else begin
            quo_q <= {quo_q[QW-2:0], div_ge};
            if (div_ge) begin
              rem_q <= rem_sub;
            end
          end
          dsh_q     <= dsh_q >> 1;
          div_cnt_q <= div_cnt_q - 6'd1;
        end
        S_YFIX: y_q <= y_fix;
        S_MUL:  prod_q <= y_q * d_q;
        S_ACC: begin
          if (fin_step) begin
            kv_q <= acc_sat;
          end else begin
            d1_q <= d_q;
            d_q  <= acc_sat;
            i_q  <= i_q - TCW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_kv_q    <= kv_q;
            out_idx_q   <= cwk_pkg::PointIdxW'(j_q);
            out_last_q  <= last_pt;
            j_q         <= j_q + PCW'(1);
            x_q         <= x_q - XW'(36'sd16777216);
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kernel_value = out_kv_q;
  assign res_o.point_index  = out_idx_q;
  assign res_o.last_point   = out_last_q;

  // ---------------- assertions ----------------
  a_term_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_ACC) |-> (i_q != '0) && (i_q <= n_lim))
    else $error("coefficient counter out of range");

  a_point_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (j_q < p_lim))
    else $error("point counter beyond points_out");

  a_last_word_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_IDLE) |=> (res_o.valid && res_o.last_point))
    else $error("item finished without a last word");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q <= 6'(cwk_pkg::DivStepsM1)))
    else $error("divider step count out of range");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !out_free) |=> (state_q == S_EMIT))
    else $error("sequencer left emit while the output was full");

endmodule

FILE: bench/chebyshev_window_kernel_evaluator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the Chebyshev window kernel evaluator: a queue-fed
// request driver, a stalling result sink, an APB register writer and a Clenshaw predictor.
// Depends on cwk_pkg, cwk_req_if, cwk_res_if and the evaluator top level.
module chebyshev_window_kernel_evaluator_tb;

  localparam int StallLimit     = 20000;
  localparam int IdleCycles     = 150;
  localparam int LongHoldAt     = 30;
  localparam int LongHoldCycles = 1500;
  localparam int RandomPhases   = 12;
  localparam int PhaseWords     = 24;
  localparam logic signed [31:0] OneQ824 = 32'sh0100_0000;

  typedef struct packed {
    logic              req_type;
    logic [4:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] position;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] kernel_value;
    logic [3:0]         point_index;
    logic               last_point;
  } kernel_point_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [cwk_pkg::PAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  cwk_req_if req_if();
  cwk_res_if res_if();

  chebyshev_window_kernel_evaluator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  req_word_t     req_backlog[$];
  kernel_point_t expected_points[$];
  req_word_t     next_word;
  kernel_point_t due_point;
  int            mismatch_cnt = 0;
  int            req_gap = 0;
  int            ready_hold = 0;
  int            ready_run = 0;
  int            words_taken = 0;
  logic          long_hold_done = 1'b0;
  int            quiet_cycles = 0;

  // Shadow of the register file and the coefficient table.
  longint dom_low    = cwk_pkg::DOMAIN_LOW_RST;
  longint dom_high   = cwk_pkg::DOMAIN_HIGH_RST;
  int     terms_cfg  = cwk_pkg::NUM_TERMS_RST;
  int     points_cfg = cwk_pkg::POINTS_OUT_RST;
  int     offset_cfg = cwk_pkg::HALF_OFFSET_RST;
  longint coef_shadow[cwk_pkg::MAX_TERMS];

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round half up: floor((v + 2^(s-1)) / 2^s).
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint map_to_unit(longint x);
    longint num, den;
    num = 2 * x - dom_low - dom_high;
    den = dom_high - dom_low;
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return sat_q((num * 64'sd268435456) / den);
  endfunction

  function automatic longint clenshaw_sum(longint y, int n);
    longint d, d1, d2;
    int i;
    d = 0;
    d1 = 0;
    for (i = n; i > 1; i--) begin
      d2 = d1;
      d1 = d;
      d = sat_q(round_shift(y * d1, 27) - d2 + coef_shadow[i - 1]);
    end
    return sat_q(round_shift(y * d, 28) - d1 + round_shift(coef_shadow[0], 1));
  endfunction

  function automatic void predict_kernel_points(logic signed [31:0] pos);
    int n, p, j;
    longint x, v;
    kernel_point_t pt;
    n = (terms_cfg > cwk_pkg::MAX_TERMS) ? cwk_pkg::MAX_TERMS : terms_cfg;
    p = (points_cfg > cwk_pkg::MAX_POINTS) ? cwk_pkg::MAX_POINTS : points_cfg;
    x = longint'(pos) + longint'(offset_cfg) * 64'sd16777216;
    for (j = 0; j < p; j++) begin
      v = clenshaw_sum(map_to_unit(x), n);
      x -= 64'sd16777216;
      pt.kernel_value = v[31:0];
      pt.point_index  = j[3:0];
      pt.last_point   = (j + 1 == p);
      expected_points.push_back(pt);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [31:0] rand_coef();
    if ($urandom_range(0, 3) != 0)
      return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] rand_position();
    if ($urandom_range(0, 9) < 7)
      return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    return $urandom;
  endfunction

  task automatic push_load(logic [4:0] idx, logic signed [31:0] v);
    req_backlog.push_back('{cwk_pkg::REQ_LOAD, idx, v, $urandom});
  endtask

  task automatic push_eval(logic signed [31:0] pos);
    req_backlog.push_back('{cwk_pkg::REQ_EVAL, 5'($urandom_range(0, 31)), $urandom, pos});
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      cwk_pkg::REG_DOMAIN_LOW:  dom_low = $signed(val);
      cwk_pkg::REG_DOMAIN_HIGH: dom_high = $signed(val);
      cwk_pkg::REG_NUM_TERMS:   terms_cfg = val[5:0];
      cwk_pkg::REG_POINTS_OUT:  points_cfg = val[4:0];
      cwk_pkg::REG_HALF_OFFSET: offset_cfg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] lo, logic [31:0] hi, int terms, int pts, int off);
    write_reg(cwk_pkg::REG_DOMAIN_LOW, lo);
    write_reg(cwk_pkg::REG_DOMAIN_HIGH, hi);
    write_reg(cwk_pkg::REG_NUM_TERMS, terms & 32'h3f);
    write_reg(cwk_pkg::REG_POINTS_OUT, pts & 32'h1f);
    write_reg(cwk_pkg::REG_HALF_OFFSET, off & 32'h1f);
    @(negedge clk_i);
  endtask

  // An evaluate word with zero points leaves nothing to wait for, so the
  // extra cycles cover a block that may still be finishing it.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || expected_points.size() != 0);
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        next_word = req_backlog.pop_front();
        req_if.req_type   <= next_word.req_type;
        req_if.coef_index <= next_word.coef_index;
        req_if.coef_value <= next_word.coef_value;
        req_if.position   <= next_word.position;
        req_if.valid      <= 1'b1;
        req_gap = pick_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, bursts of full throughput, one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) words_taken++;
      if (!long_hold_done && words_taken >= LongHoldAt) begin
        long_hold_done = 1'b1;
        ready_hold = LongHoldCycles;
        res_if.ready <= 1'b0;
      end else if (ready_hold > 0) begin
        ready_hold--;
        res_if.ready <= 1'b0;
      end else if (ready_run > 0) begin
        ready_run--;
        res_if.ready <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        ready_run = $urandom_range(20, 200);
        res_if.ready <= 1'b1;
      end else begin
        ready_hold = pick_gap();
        res_if.ready <= (ready_hold == 0);
      end
    end
  end

  // Prediction happens before the check so a word and a result at the same
  // edge are handled in a fixed order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        if (req_if.req_type == cwk_pkg::REQ_LOAD)
          coef_shadow[req_if.coef_index] = longint'(req_if.coef_value);
        else
          predict_kernel_points(req_if.position);
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected word value %h index %0d last %b",
                                    res_if.kernel_value, res_if.point_index,
                                    res_if.last_point));
        end else begin
          due_point = expected_points.pop_front();
          if (res_if.kernel_value !== due_point.kernel_value)
            report_mismatch($sformatf("point %0d kernel_value %h, expected %h",
                                      due_point.point_index, res_if.kernel_value,
                                      due_point.kernel_value));
          if (res_if.point_index !== due_point.point_index)
            report_mismatch($sformatf("point_index %0d, expected %0d",
                                      res_if.point_index, due_point.point_index));
          if (res_if.last_point !== due_point.last_point)
            report_mismatch($sformatf("point %0d last_point %b, expected %b",
                                      due_point.point_index, res_if.last_point,
                                      due_point.last_point));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] lo, hi;
    int k, ph, terms, pts, off;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = cwk_pkg::REQ_LOAD;
    req_if.coef_index = '0;
    req_if.coef_value = '0;
    req_if.position   = '0;
    res_if.ready      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every coefficient entry is written before the first evaluation.
    for (k = 0; k < cwk_pkg::MAX_TERMS; k++) push_load(k[4:0], rand_coef());
    push_eval(32'sh0);
    push_eval(32'sh7fff_ffff);
    push_eval(32'sh8000_0000);
    push_eval(OneQ824);
    push_eval(-OneQ824);
    push_load(5'd0, 32'sh7fff_ffff);
    push_eval(32'sh0);
    push_load(5'd0, 32'sh8000_0000);
    push_load(5'd15, 32'sh7fff_ffff);
    push_eval(32'sh0080_0000);
    push_load(5'd15, 32'sh8000_0000);
    push_eval(-32'sh0080_0000);
    push_load(5'd0, rand_coef());
    push_load(5'd15, rand_coef());

    // Empty domain: the three points land above, on and below the bound.
    wait_idle();
    set_config(OneQ824, OneQ824, 4, 3, 0);
    push_eval(2 * OneQ824);

    // Reversed domain.
    wait_idle();
    set_config(OneQ824, -OneQ824, 5, 4, 2);
    push_eval(32'sh0);
    push_eval(32'sh1234_5678);

    // Zero terms over the widest domain.
    wait_idle();
    set_config(32'h8000_0000, 32'h7fff_ffff, 0, 2, 0);
    push_eval(32'sh0);

    // Zero points: the evaluate word gives nothing.
    wait_idle();
    set_config(-OneQ824, OneQ824, 63, 0, 31);
    push_eval(32'sh0);
    push_load(5'd31, rand_coef());

    // Points and terms both above their limits, largest offset.
    wait_idle();
    set_config(-2 * OneQ824, 2 * OneQ824, 63, 31, 31);
    push_eval(-16 * OneQ824);

    wait_idle();
    set_config(-OneQ824, OneQ824, 1, 1, 0);
    push_eval(OneQ824 / 2);

    wait_idle();
    set_config(-OneQ824, OneQ824, 32, 16, 16);
    push_eval(-8 * OneQ824);

    for (ph = 0; ph < RandomPhases; ph++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin
          lo = $urandom;
          hi = lo;
        end
        2: begin
          lo = 32'h8000_0000;
          hi = 32'h7fff_ffff;
        end
        default: begin
          lo = -int'($urandom_range(32'h0040_0000, 32'h0800_0000));
          hi = $urandom_range(32'h0040_0000, 32'h0800_0000);
        end
      endcase
      terms = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 63);
      pts   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31);
      off   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 31);
      set_config(lo, hi, terms, pts, off);
      for (k = 0; k < PhaseWords; k++) begin
        if ($urandom_range(0, 9) < 4) push_load(5'($urandom_range(0, 31)), rand_coef());
        else push_eval(rand_position());
      end
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/cwk_pkg.sv
design/cwk_req_if.sv
design/cwk_res_if.sv
design/cwk_ram.sv
design/chebyshev_window_kernel_evaluator.sv
bench/chebyshev_window_kernel_evaluator_tb.sv
